// File: rtl/phor_pkg.sv
// Package with shared types, constants and register map of the occupancy reporter.
`timescale 1ns / 1ps

package phor_pkg;

    // Register map: byte address = 4 * index.
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_HOLD     = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTERVAL = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP     = 3'd2;
    localparam logic [IDX_W-1:0] REG_ACTIVE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ENERGY   = 3'd4;
    localparam logic [IDX_W-1:0] REG_PRICE    = 3'd5;

    // Field widths.
    localparam int unsigned MS_W     = 22;
    localparam int unsigned STEP_W   = 10;
    localparam int unsigned EPS_W    = 10;
    localparam int unsigned PRICE_W  = 14;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SECS_W   = 23;
    localparam int unsigned COST_W   = 46;

    // Reset values of the configuration registers.
    localparam logic [MS_W-1:0]    HOLD_RST     = 22'd30000;
    localparam logic [MS_W-1:0]    INTERVAL_RST = 22'd30000;
    localparam logic [STEP_W-1:0]  STEP_RST     = 10'd10;
    localparam logic               ACTIVE_RST   = 1'b1;
    localparam logic [EPS_W-1:0]   EPS_RST      = 10'd167;
    localparam logic [PRICE_W-1:0] PRICE_RST    = 14'd92;

    // Wall-clock values below this are treated as an unset clock.
    localparam logic [TIME_W-1:0] EPOCH_FLOOR = 32'd1700000000;

    // Shared multiplier: 32-bit by 30-bit operands.
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 30;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    // x / 1000 = ((x >> 3) * DIV_MAGIC) >> DIV_SHIFT, exact for any 32-bit x.
    localparam int unsigned          DIV_PRE   = 3;
    localparam int unsigned          DIV_SHIFT = 36;
    localparam logic [MUL_B_W-1:0]   DIV_MAGIC = 30'd549755814;

    typedef struct packed {
        logic [MS_W-1:0]    hold_ms;
        logic [MS_W-1:0]    report_interval_ms;
        logic [STEP_W-1:0]  poll_step_ms;
        logic               active_level;
        logic [EPS_W-1:0]   energy_per_second;
        logic [PRICE_W-1:0] price_per_kwh;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // take the input beat and update tick state
        logic mul_div;   // on-time times reciprocal of 1000
        logic mul_ener;  // seconds times energy rate
        logic mul_cost;  // saturated energy times price
        logic load_out;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic report;    // the tick in hand closes a window
        logic out_free;  // output register can take a result this cycle
    } t_stat;

endpackage

// File: rtl/phor_regs.sv
// APB-style configuration register file of the occupancy reporter.
`timescale 1ns / 1ps

module phor_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phor_pkg::ADDR_W-1:0]   paddr,
    input  logic [phor_pkg::DATA_W-1:0]   pwdata,
    output logic [phor_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output phor_pkg::t_cfg                o_cfg
);

    phor_pkg::t_cfg              r_cfg;
    logic [phor_pkg::IDX_W-1:0]  w_idx;
    logic                        w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[phor_pkg::ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ms            <= phor_pkg::HOLD_RST;
            r_cfg.report_interval_ms <= phor_pkg::INTERVAL_RST;
            r_cfg.poll_step_ms       <= phor_pkg::STEP_RST;
            r_cfg.active_level       <= phor_pkg::ACTIVE_RST;
            r_cfg.energy_per_second  <= phor_pkg::EPS_RST;
            r_cfg.price_per_kwh      <= phor_pkg::PRICE_RST;
        end else if (w_wr) begin
            case (w_idx)
                phor_pkg::REG_HOLD:
                    r_cfg.hold_ms <= pwdata[phor_pkg::MS_W-1:0];
                phor_pkg::REG_INTERVAL:
                    r_cfg.report_interval_ms <= pwdata[phor_pkg::MS_W-1:0];
                phor_pkg::REG_STEP:
                    r_cfg.poll_step_ms <= pwdata[phor_pkg::STEP_W-1:0];
                phor_pkg::REG_ACTIVE:
                    r_cfg.active_level <= pwdata[0];
                phor_pkg::REG_ENERGY:
                    r_cfg.energy_per_second <= pwdata[phor_pkg::EPS_W-1:0];
                phor_pkg::REG_PRICE:
                    r_cfg.price_per_kwh <= pwdata[phor_pkg::PRICE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            phor_pkg::REG_HOLD:     prdata = {10'd0, r_cfg.hold_ms};
            phor_pkg::REG_INTERVAL: prdata = {10'd0, r_cfg.report_interval_ms};
            phor_pkg::REG_STEP:     prdata = {22'd0, r_cfg.poll_step_ms};
            phor_pkg::REG_ACTIVE:   prdata = {31'd0, r_cfg.active_level};
            phor_pkg::REG_ENERGY:   prdata = {22'd0, r_cfg.energy_per_second};
            phor_pkg::REG_PRICE:    prdata = {18'd0, r_cfg.price_per_kwh};
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/phor_ctrl.sv
// Controller state machine that sequences one tick through the datapath.
`timescale 1ns / 1ps

module phor_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  phor_pkg::t_stat  i_stat,
    output phor_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ENER = 3'd2;
    localparam logic [2:0] S_COST = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.report ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.mul_div = 1'b1;
                n_state       = S_ENER;
            end
            S_ENER: begin
                o_cmd.mul_ener = 1'b1;
                n_state        = S_COST;
            end
            S_COST: begin
                o_cmd.mul_cost = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/phor_dp.sv
// Datapath: tick state, shared multiplier and output register.
`timescale 1ns / 1ps

module phor_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  phor_pkg::t_cfg                  i_cfg,
    input  phor_pkg::t_cmd                  i_cmd,
    output phor_pkg::t_stat                 o_stat,
    input  logic [phor_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                            i_sensor_level,
    input  logic [phor_pkg::TIME_W-1:0]     i_wall_clock_s,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic                            o_light_on,
    output logic                            o_report_valid,
    output logic [phor_pkg::SECS_W-1:0]     o_report_seconds_on,
    output logic [phor_pkg::TIME_W-1:0]     o_report_motion_count,
    output logic                            o_report_presence,
    output logic [phor_pkg::TIME_W-1:0]     o_report_energy,
    output logic [phor_pkg::COST_W-1:0]     o_report_cost,
    output logic [phor_pkg::TIME_W-1:0]     o_report_epoch
);

    localparam int unsigned TW = phor_pkg::TIME_W;

    // Architectural tick state.
    logic [TW-1:0] r_window_start;
    logic [TW-1:0] r_last_motion;
    logic [TW-1:0] r_on_time;
    logic [TW-1:0] r_edge_count;
    logic          r_ever_seen;
    logic          r_prev_motion;

    // Per-tick work registers.
    logic          r_light;
    logic          r_report;
    logic [TW-1:0] r_on_snap;
    logic [TW-1:0] r_cnt_snap;
    logic [TW-1:0] r_epoch;
    logic [phor_pkg::SECS_W-1:0] r_secs;
    logic [TW-1:0] r_energy;
    logic [phor_pkg::PROD_W-1:0] r_prod;

    // Output register.
    logic          r_out_valid;

    logic          n_motion;
    logic          n_light;
    logic [TW:0]   n_on_sum;
    logic [TW-1:0] n_on_time;
    logic [TW-1:0] n_edge_count;
    logic          n_report;
    logic [TW-1:0] n_since_motion;
    logic [TW-1:0] n_since_window;
    logic [phor_pkg::SECS_W-1:0] n_secs;
    logic [TW-1:0] n_energy;
    logic [phor_pkg::MUL_A_W-1:0] n_mul_a;
    logic [phor_pkg::MUL_B_W-1:0] n_mul_b;

    always_comb begin
        n_motion       = (i_sensor_level == i_cfg.active_level);
        n_since_motion = i_now_ms - r_last_motion;
        n_light        = n_motion
                       | (r_ever_seen & (n_since_motion <= {10'd0, i_cfg.hold_ms}));
        n_on_sum       = {1'b0, r_on_time} + {23'd0, i_cfg.poll_step_ms};
        if (!n_light) begin
            n_on_time = r_on_time;
        end else if (n_on_sum[TW]) begin
            n_on_time = '1;
        end else begin
            n_on_time = n_on_sum[TW-1:0];
        end
        if (n_motion && !r_prev_motion && (r_edge_count != '1)) begin
            n_edge_count = r_edge_count + 32'd1;
        end else begin
            n_edge_count = r_edge_count;
        end
        n_since_window = i_now_ms - r_window_start;
        n_report       = (n_since_window >= {10'd0, i_cfg.report_interval_ms});
    end

    assign o_stat.report   = n_report;
    assign o_stat.out_free = !r_out_valid || i_ready;

    // Shared multiplier operand selection.
    always_comb begin
        n_secs   = r_prod[phor_pkg::DIV_SHIFT +: phor_pkg::SECS_W];
        n_energy = (|r_prod[phor_pkg::PROD_W-1:TW]) ? '1 : r_prod[TW-1:0];
        n_mul_a  = '0;
        n_mul_b  = '0;
        if (i_cmd.mul_div) begin
            n_mul_a = {{phor_pkg::DIV_PRE{1'b0}}, r_on_snap[TW-1:phor_pkg::DIV_PRE]};
            n_mul_b = phor_pkg::DIV_MAGIC;
        end else if (i_cmd.mul_ener) begin
            n_mul_a = {9'd0, n_secs};
            n_mul_b = {20'd0, i_cfg.energy_per_second};
        end else if (i_cmd.mul_cost) begin
            n_mul_a = n_energy;
            n_mul_b = {16'd0, i_cfg.price_per_kwh};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start <= '0;
            r_last_motion  <= '0;
            r_on_time      <= '0;
            r_edge_count   <= '0;
            r_ever_seen    <= 1'b0;
            r_prev_motion  <= 1'b0;
        end else if (i_cmd.accept) begin
            if (n_motion) begin
                r_last_motion <= i_now_ms;
                r_ever_seen   <= 1'b1;
            end
            r_prev_motion <= n_motion;
            if (n_report) begin
                r_window_start <= i_now_ms;
                r_on_time      <= '0;
                r_edge_count   <= '0;
            end else begin
                r_on_time    <= n_on_time;
                r_edge_count <= n_edge_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_light    <= n_light;
            r_report   <= n_report;
            r_on_snap  <= n_on_time;
            r_cnt_snap <= n_edge_count;
            r_epoch    <= (i_wall_clock_s < phor_pkg::EPOCH_FLOOR) ? '0 : i_wall_clock_s;
        end
        if (i_cmd.mul_div || i_cmd.mul_ener || i_cmd.mul_cost) begin
            r_prod <= n_mul_a * n_mul_b;
        end
        if (i_cmd.mul_ener) begin
            r_secs <= n_secs;
        end
        if (i_cmd.mul_cost) begin
            r_energy <= n_energy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_light_on     <= r_light;
            o_report_valid <= r_report;
            if (r_report) begin
                o_report_seconds_on   <= r_secs;
                o_report_motion_count <= r_cnt_snap;
                o_report_presence     <= r_light;
                o_report_energy       <= r_energy;
                o_report_cost         <= r_prod[phor_pkg::COST_W-1:0];
                o_report_epoch        <= r_epoch;
            end else begin
                o_report_seconds_on   <= '0;
                o_report_motion_count <= '0;
                o_report_presence     <= 1'b0;
                o_report_energy       <= '0;
                o_report_cost         <= '0;
                o_report_epoch        <= '0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: rtl/presence_hold_occupancy_report.sv
// Top level of the presence-hold occupancy reporter.
`timescale 1ns / 1ps

// Usage overview.
// Each input beat (i_valid/o_ready) is one poll tick: a millisecond timestamp,
// the raw sensor level and the wall-clock seconds. Every tick produces exactly
// one output beat (o_valid/i_ready) carrying the light drive and, when the tick
// closes a reporting window, the report fields; otherwise those fields are zero.
// A tick that does not close a window goes from acceptance straight to the done
// state. A tick that closes a window first makes three passes through one
// shared 32 by 30 bit multiplier: divide on-time by 1000 through a reciprocal,
// multiply seconds by the energy rate, then saturated energy by the price.
// In the done state the result enters the output register, raising o_valid.
// The output register decouples the two sides: a new tick is accepted while an
// earlier result still waits. When the receiver stalls, the finished result is
// held in the datapath while the controller waits for the output register to
// free up, and no further tick is accepted meanwhile.
// The configuration registers sit on an APB-style port at byte address 4 times
// the register index; pready is always high and writes should only happen
// while the block is idle.
// A synchronous active-low reset loads the register defaults, clears the tick
// state (window start, last motion, on-time, edge count, motion history) and
// empties the output register.

module presence_hold_occupancy_report (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [phor_pkg::ADDR_W-1:0]     paddr,
    input  logic [phor_pkg::DATA_W-1:0]     pwdata,
    output logic [phor_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    // tick input
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [phor_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                            i_sensor_level,
    input  logic [phor_pkg::TIME_W-1:0]     i_wall_clock_s,
    // result output
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_light_on,
    output logic                            o_report_valid,
    output logic [phor_pkg::SECS_W-1:0]     o_report_seconds_on,
    output logic [phor_pkg::TIME_W-1:0]     o_report_motion_count,
    output logic                            o_report_presence,
    output logic [phor_pkg::TIME_W-1:0]     o_report_energy,
    output logic [phor_pkg::COST_W-1:0]     o_report_cost,
    output logic [phor_pkg::TIME_W-1:0]     o_report_epoch
);

    phor_pkg::t_cfg  w_cfg;
    phor_pkg::t_cmd  w_cmd;
    phor_pkg::t_stat w_stat;

    // Register file holds the six settings that steer the datapath.
    phor_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The controller decides when a tick is taken, how many multiplier
    // passes it needs and when its result may enter the output register.
    phor_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // The datapath updates the hold timer, window and accumulators in the
    // acceptance cycle and then computes the report arithmetic.
    phor_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (w_cfg),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_now_ms              (i_now_ms),
        .i_sensor_level        (i_sensor_level),
        .i_wall_clock_s        (i_wall_clock_s),
        .i_ready               (i_ready),
        .o_valid               (o_valid),
        .o_light_on            (o_light_on),
        .o_report_valid        (o_report_valid),
        .o_report_seconds_on   (o_report_seconds_on),
        .o_report_motion_count (o_report_motion_count),
        .o_report_presence     (o_report_presence),
        .o_report_energy       (o_report_energy),
        .o_report_cost         (o_report_cost),
        .o_report_epoch        (o_report_epoch)
    );

endmodule

// File: rtl/phor_checker.sv
// Port-level checker for the occupancy reporter and its bind statement.
`timescale 1ns / 1ps

module phor_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  logic                            o_light_on,
    input  logic                            o_report_valid,
    input  logic [phor_pkg::SECS_W-1:0]     o_report_seconds_on,
    input  logic [phor_pkg::TIME_W-1:0]     o_report_motion_count,
    input  logic                            o_report_presence,
    input  logic [phor_pkg::TIME_W-1:0]     o_report_energy,
    input  logic [phor_pkg::COST_W-1:0]     o_report_cost,
    input  logic [phor_pkg::TIME_W-1:0]     o_report_epoch
);

    // A beat that closes no window carries an all-zero report.
    a_quiet_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_report_valid) |->
            (o_report_seconds_on == '0) && (o_report_motion_count == '0)
            && (o_report_energy == '0) && (o_report_cost == '0)
            && (o_report_epoch == '0))
        else $error("report fields nonzero on a beat without a report");

    // Presence in a report mirrors the light drive of the same beat.
    a_presence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_report_presence == (o_report_valid & o_light_on)))
        else $error("report presence disagrees with light drive");

    // An unset wall clock reports epoch zero, never a value below the floor.
    a_epoch_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_report_epoch != '0)) |->
            (o_report_epoch >= phor_pkg::EPOCH_FLOOR))
        else $error("report epoch below validity floor");

    // A stalled result beat holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            o_valid && $stable(o_report_cost) && $stable(o_light_on)
            && $stable(o_report_motion_count))
        else $error("result beat changed while stalled");

endmodule

bind presence_hold_occupancy_report phor_checker u_phor_checker (.*);
